@@ rtl/mace_pkg.sv @@
package mace_pkg;

   // field widths
   localparam int DATA_W    = 32;
   localparam int INDEX_W   = 6;
   localparam int OBS_W     = 16;
   localparam int HEIGHT_W  = 48;
   localparam int CUT_IDX_W = 10;
   localparam int ACC_W     = 64;

   // shared multiplier operand width (signed 32 bit or unsigned 32 bit fits)
   localparam int MUL_W     = 33;

   // bit-serial divider
   localparam int DIV_W     = 64;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_COEF = 1'b1;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LB_NONTRIVIAL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_BOUND      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_ITERATION = 2'd2;

   // 48 bit saturation limits
   localparam logic signed [HEIGHT_W-1:0] MAX48 = {1'b0, {(HEIGHT_W-1){1'b1}}};
   localparam logic signed [HEIGHT_W-1:0] MIN48 = {1'b1, {(HEIGHT_W-1){1'b0}}};

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ rtl/mace_mult.sv @@
module mace_mult (
   input  logic                                      clock,
   input  logic                                      en,
   input  logic signed [mace_pkg::MUL_W-1:0]         a,
   input  logic signed [mace_pkg::MUL_W-1:0]         b,
   output logic signed [2*mace_pkg::MUL_W-1:0]       prod
);

   logic signed [2*mace_pkg::MUL_W-1:0] prod_ff;
   logic signed [2*mace_pkg::MUL_W-1:0] prod_in;

   // one signed product per cycle while en is high, registered
   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

@@ rtl/mace_div.sv @@
module mace_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [mace_pkg::DIV_W-1:0]      dividend,
   input  logic        [mace_pkg::OBS_W-1:0]      divisor,
   output mace_pkg::div_status_type               status,
   output logic signed [mace_pkg::DIV_W-1:0]      quotient
);

   localparam int W  = mace_pkg::DIV_W;
   localparam int CW = mace_pkg::DIV_CNT_W;
   localparam int RW = mace_pkg::OBS_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic          neg_ff, neg_in;
   logic [RW-1:0] dvs_ff, dvs_in;

   logic [RW:0]   trial;
   logic          ge;

   // restoring step: one quotient bit per cycle, magnitude only
   assign trial = {rem_ff, quo_ff[W-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         rem_in  = '0;
         neg_in  = dividend[W-1];
         quo_in  = dividend[W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? RW'(trial - {1'b0, dvs_ff}) : trial[RW-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
   end

   // truncation toward zero: restore sign of the magnitude quotient
   assign quotient    = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ rtl/max_affine_cut_evaluator.sv @@
// Point load: loads may follow back to back while the sequencer is idle.
// Coefficient beat: point read, shared multiply, accumulate.
// Last coefficient of a cut adds the height: one division, two with the
//   lower-bound term; each runs through the one-bit-per-cycle 64 bit divider.
// Last cut adds an emit step for the output register. Synchronous active-high
//   reset clears control, configuration and the running max; point store keeps.
module max_affine_cut_evaluator #(
   parameter int VECTOR_LENGTH = 64,
   parameter int MAX_CUTS      = 1024
) (
   input  logic                                      clock,
   input  logic                                      reset,

   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_cmd,
   input  logic        [mace_pkg::INDEX_W-1:0]       req_element_index,
   input  logic signed [mace_pkg::DATA_W-1:0]        req_element_value,
   input  logic signed [mace_pkg::DATA_W-1:0]        req_cut_constant,
   input  logic        [mace_pkg::OBS_W-1:0]         req_cut_observations,
   input  logic                                      req_last_of_cut,
   input  logic                                      req_last_cut,

   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [mace_pkg::HEIGHT_W-1:0]      rsp_max_height,
   output logic        [mace_pkg::CUT_IDX_W-1:0]     rsp_best_cut_index,

   input  logic                                      csr_write_en,
   input  logic        [mace_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic        [mace_pkg::DATA_W-1:0]        csr_wdata
);

   localparam int DW     = mace_pkg::DATA_W;
   localparam int AW     = mace_pkg::ACC_W;
   localparam int HW     = mace_pkg::HEIGHT_W;
   localparam int OW     = mace_pkg::OBS_W;
   localparam int MW     = mace_pkg::MUL_W;
   localparam int ADDR_W = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
   localparam int CNT_W  = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_ACC   = 4'd2;
   localparam logic [3:0] S_DIFF  = 4'd3;
   localparam logic [3:0] S_MHI   = 4'd4;
   localparam logic [3:0] S_MLO   = 4'd5;
   localparam logic [3:0] S_NUM   = 4'd6;
   localparam logic [3:0] S_DIV1  = 4'd7;
   localparam logic [3:0] S_MLB   = 4'd8;
   localparam logic [3:0] S_LBDIV = 4'd9;
   localparam logic [3:0] S_DIV2  = 4'd10;
   localparam logic [3:0] S_CMP   = 4'd11;
   localparam logic [3:0] S_EMIT  = 4'd12;

   logic [3:0] state_ff, state_in;

   // configuration
   logic                 lb_nontrivial_ff;
   logic signed [DW-1:0] lower_bound_ff;
   logic [OW-1:0]        iteration_ff;

   // latched beat
   logic signed [DW-1:0] val_ff;
   logic signed [DW-1:0] alpha_ff;
   logic [OW-1:0]        obs_ff;
   logic                 in_range_ff;
   logic                 last_of_cut_ff;
   logic                 last_cut_ff;

   // point store
   logic [DW-1:0]        point_mem [VECTOR_LENGTH];
   logic [DW-1:0]        rd_data_ff;
   logic [ADDR_W-1:0]    addr;
   logic                 in_range;

   // datapath state
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [HW-1:0] d_ff;
   logic signed [AW-1:0] num_ff;
   logic signed [AW-1:0] q1_ff;
   logic signed [AW-1:0] q2_ff;
   logic signed [HW-1:0] running_max_ff;
   logic [CNT_W-1:0]     best_idx_ff;
   logic [CNT_W-1:0]     cut_cnt_ff;
   logic                 have_cut_ff;

   // output register
   logic                 rsp_valid_ff;
   logic signed [HW-1:0] rsp_max_height_ff;
   logic [CNT_W-1:0]     rsp_idx_ff;

   logic                 req_beat;
   logic                 emit_go;

   // shared multiplier
   logic                   mul_en;
   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] mul_prod;
   logic signed [AW-1:0]   prod;

   // divider
   logic                      div_start;
   logic signed [AW-1:0]      div_dividend;
   mace_pkg::div_status_type  div_status;
   logic signed [AW-1:0]      div_quotient;

   // iteration count and clamped observations
   logic [OW-1:0]        k_eff;
   logic [OW-1:0]        obs_c;
   logic [OW-1:0]        k_minus_obs;

   // saturating arithmetic
   logic [AW:0]          acc_sum;
   logic signed [AW-1:0] alpha_q;
   logic [AW:0]          diff;
   logic signed [AW-1:0] diff_sat;
   logic signed [AW-1:0] hsum;
   logic signed [HW-1:0] h;

   assign req_ready = (state_ff == S_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign addr      = ADDR_W'(req_element_index);
   assign in_range  = (32'(req_element_index) < VECTOR_LENGTH);
   assign emit_go   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign k_eff       = (iteration_ff == '0) ? OW'(1) : iteration_ff;
   assign obs_c       = (obs_ff > k_eff) ? k_eff : obs_ff;
   assign k_minus_obs = k_eff - obs_c;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lb_nontrivial_ff <= 1'b0;
         lower_bound_ff   <= '0;
         iteration_ff     <= OW'(1);
      end else if (csr_write_en) begin
         unique case (csr_index)
            mace_pkg::CSR_LB_NONTRIVIAL:     lb_nontrivial_ff <= csr_wdata[0];
            mace_pkg::CSR_LOWER_BOUND:       lower_bound_ff   <= csr_wdata;
            mace_pkg::CSR_CURRENT_ITERATION: iteration_ff     <= csr_wdata[OW-1:0];
            default: ;
         endcase
      end
   end

   // point store: write on load beats, registered read on coefficient beats
   always_ff @(posedge clock) begin
      if (req_beat && (req_cmd == mace_pkg::CMD_LOAD) && in_range) begin
         point_mem[addr] <= req_element_value;
      end
      if (req_beat && (req_cmd == mace_pkg::CMD_COEF)) begin
         rd_data_ff <= point_mem[addr];
      end
   end

   // latch coefficient beat fields
   always_ff @(posedge clock) begin
      if (req_beat && (req_cmd == mace_pkg::CMD_COEF)) begin
         val_ff         <= req_element_value;
         alpha_ff       <= req_cut_constant;
         obs_ff         <= req_cut_observations;
         in_range_ff    <= in_range;
         last_of_cut_ff <= req_last_of_cut;
         last_cut_ff    <= req_last_cut;
      end
   end

   // multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      unique case (state_ff)
         S_MUL: begin
            mul_a = {val_ff[DW-1], val_ff};
            mul_b = {rd_data_ff[DW-1], rd_data_ff};
         end
         S_MHI: begin
            mul_a = {d_ff[HW-1], d_ff[HW-1:16]};
            mul_b = {{(MW-OW){1'b0}}, obs_c};
         end
         S_MLO: begin
            mul_a = {{(MW-16){1'b0}}, d_ff[15:0]};
            mul_b = {{(MW-OW){1'b0}}, obs_c};
         end
         S_MLB: begin
            mul_a = {lower_bound_ff[DW-1], lower_bound_ff};
            mul_b = {{(MW-OW){1'b0}}, k_minus_obs};
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   mace_mult u_mult (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod)
   );

   assign prod = mul_prod[AW-1:0];

   // divider start and dividend select
   assign div_start    = (state_ff == S_NUM) || (state_ff == S_LBDIV);
   assign div_dividend = (state_ff == S_NUM) ? (num_ff + prod) : prod;

   mace_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (k_eff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // saturating accumulate of beta*x
   assign acc_sum = {acc_ff[AW-1], acc_ff} + {prod[AW-1], prod};
   always_comb begin
      if (acc_sum[AW] != acc_sum[AW-1]) begin
         acc_in = acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end else begin
         acc_in = acc_sum[AW-1:0];
      end
   end

   // alpha<<16 minus dot product, saturated to 64 bits
   assign alpha_q = {{16{alpha_ff[DW-1]}}, alpha_ff, 16'b0};
   assign diff    = {alpha_q[AW-1], alpha_q} - {acc_ff[AW-1], acc_ff};
   always_comb begin
      if (diff[AW] != diff[AW-1]) begin
         diff_sat = diff[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end else begin
         diff_sat = diff[AW-1:0];
      end
   end

   // weighted height saturated to 48 bits
   assign hsum = q1_ff + q2_ff;
   always_comb begin
      if ((&hsum[AW-1:HW-1]) || !(|hsum[AW-1:HW-1])) begin
         h = hsum[HW-1:0];
      end else begin
         h = hsum[AW-1] ? mace_pkg::MIN48 : mace_pkg::MAX48;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_beat && (req_cmd == mace_pkg::CMD_COEF)) state_in = S_MUL;
         S_MUL:   state_in = S_ACC;
         S_ACC:   state_in = last_of_cut_ff ? S_DIFF : S_IDLE;
         S_DIFF:  state_in = S_MHI;
         S_MHI:   state_in = S_MLO;
         S_MLO:   state_in = S_NUM;
         S_NUM:   state_in = S_DIV1;
         S_DIV1: begin
            if (div_status.done) state_in = lb_nontrivial_ff ? S_MLB : S_CMP;
         end
         S_MLB:   state_in = S_LBDIV;
         S_LBDIV: state_in = S_DIV2;
         S_DIV2:  if (div_status.done) state_in = S_CMP;
         S_CMP:   state_in = last_cut_ff ? S_EMIT : S_IDLE;
         S_EMIT:  if (emit_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers without reset
   always_ff @(posedge clock) begin
      if (state_ff == S_DIFF) begin
         d_ff <= diff_sat[AW-1:16];
      end
      if (state_ff == S_MLO) begin
         num_ff <= {prod[HW-1:0], 16'b0};
      end
      if ((state_ff == S_DIV1) && div_status.done) begin
         q1_ff <= div_quotient;
         q2_ff <= '0;
      end
      if ((state_ff == S_DIV2) && div_status.done) begin
         q2_ff <= div_quotient;
      end
   end

   // accumulator and running max of the set
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff         <= '0;
         running_max_ff <= mace_pkg::MIN48;
         best_idx_ff    <= '0;
         cut_cnt_ff     <= '0;
         have_cut_ff    <= 1'b0;
      end else begin
         if ((state_ff == S_ACC) && in_range_ff) begin
            acc_ff <= acc_in;
         end else if (state_ff == S_DIFF) begin
            acc_ff <= '0;
         end
         if (state_ff == S_CMP) begin
            // first cut of a set always wins; ties keep the earlier index
            if (!have_cut_ff || (h > running_max_ff)) begin
               running_max_ff <= h;
               best_idx_ff    <= cut_cnt_ff;
               have_cut_ff    <= 1'b1;
            end
            if (cut_cnt_ff < CNT_W'(MAX_CUTS - 1)) begin
               cut_cnt_ff <= cut_cnt_ff + CNT_W'(1);
            end
         end else if (emit_go) begin
            running_max_ff <= mace_pkg::MIN48;
            best_idx_ff    <= '0;
            cut_cnt_ff     <= '0;
            have_cut_ff    <= 1'b0;
         end
      end
   end

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_go) begin
         rsp_max_height_ff <= running_max_ff;
         rsp_idx_ff        <= best_idx_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_max_height     = rsp_max_height_ff;
   assign rsp_best_cut_index = mace_pkg::CUT_IDX_W'(rsp_idx_ff);

   // divider is free whenever the sequencer starts it
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // a result beat only appears from the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result beat raised outside emit");

   // empty set holds the reset max and index
   a_empty_set: assert property (@(posedge clock) disable iff (reset)
      !have_cut_ff |-> (running_max_ff == mace_pkg::MIN48) && (best_idx_ff == '0))
      else $error("running max set without a cut");

   // best index never runs ahead of the cut counter
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      best_idx_ff <= cut_cnt_ff)
      else $error("best cut index beyond cut counter");

endmodule
